// File: src/gdps_pkg.sv
// ----------------------------------------------------------------------------
// gdps_pkg: shared types and constants for the glyph page stream renderer
// Field widths, item and command codes, and the nibble spreading function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdps_pkg;

  // Input and output field widths
  localparam int unsigned FONT_ADDR_W = 11;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ADDR_EXT_W  = 12;  // glyph index (8) + page half (1) + row (3)
  localparam int unsigned GIDX_W      = 8;
  localparam int unsigned COL_W       = 4;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned PAGE_W      = 2;

  // Item codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // First printable character code
  localparam logic [BYTE_W-1:0] CODE_BASE = 8'd32;

  // Controller command bytes
  localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'hB0;
  localparam logic [BYTE_W-1:0] CMD_COL_HI = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_COL_LO = 8'h01;

  // Steps within one page: three commands, then eight data bytes
  localparam logic [STEP_W-1:0] STEP_CMD_PAGE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CMD_HI   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CMD_LO   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DATA0    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LAST     = 4'd10;
  localparam logic [PAGE_W-1:0] PAGE_LAST     = 2'd3;

  // Position and context of the byte being produced
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [STEP_W-1:0] step;
    logic [COL_W-1:0]  col;
    logic              trow;
    logic              glyph_ok;
  } pos_t;

  // Move nibble bit k to byte bit 2k+1
  function automatic logic [BYTE_W-1:0] spread_nibble(input logic [3:0] nib);
    spread_nibble = {nib[3], 1'b0, nib[2], 1'b0, nib[1], 1'b0, nib[0], 1'b0};
  endfunction

endpackage

// File: src/gdps_if.sv
// ----------------------------------------------------------------------------
// gdps_in_if / gdps_out_if: valid-ready channels of the renderer
// Item channel (loads and draws) and byte channel toward the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gdps_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [gdps_pkg::FONT_ADDR_W-1:0]    font_addr;
  logic [gdps_pkg::BYTE_W-1:0]         font_byte;
  logic [gdps_pkg::BYTE_W-1:0]         char_code;

  modport source (output valid, op, font_addr, font_byte, char_code, input ready);
  modport sink   (input valid, op, font_addr, font_byte, char_code, output ready);
endinterface

interface gdps_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_data;
  logic [gdps_pkg::BYTE_W-1:0] out_byte;
  logic                        last;

  modport source (output valid, is_data, out_byte, last, input ready);
  modport sink   (input valid, is_data, out_byte, last, output ready);
endinterface

// File: src/glyph_to_display_page_stream_core.sv
// ----------------------------------------------------------------------------
// glyph_to_display_page_stream_core: 8x16 glyph renderer, stretched to 32 rows
// Loads a glyph memory and streams page commands and pixel bytes per character.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items. A load item (op = 0) writes font_byte at font_addr in
//   the glyph memory and produces nothing. A draw item (op = 1)
//   renders char_code at the current text slot and produces 44 bytes on
//   out_ch: per page, three positioning commands then eight data bytes.
//   out_ch.last marks the final byte of a draw.
//   A draw transfer first sets the draw state; the output register then loads
//   the first byte. Throughput: one byte per cycle while out_ch.ready is high;
//   in_ch.ready is low while a draw runs, until its final byte is loaded, and
//   loads may arrive back to back.
//   Stalls: a low out_ch.ready holds the output register and freezes the
//   sequencer; no byte is lost. A load or the next draw may be accepted while
//   the final byte of a draw still waits.
//   Reset (rst_n low, synchronous) returns to idle and the slot to zero; the
//   glyph memory keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_to_display_page_stream_core #(
  parameter int unsigned GLYPH_COUNT   = 96,
  parameter int unsigned CHARS_PER_ROW = 16,
  parameter int unsigned TEXT_ROWS     = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  gdps_in_if.sink    in_ch,
  gdps_out_if.source out_ch
);

  localparam int unsigned DEPTH = GLYPH_COUNT * 16;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [gdps_pkg::BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [gdps_pkg::BYTE_W-1:0] ram_rdata;
  gdps_pkg::pos_t              pos;
  logic                        fmt_is_data;
  logic [gdps_pkg::BYTE_W-1:0] fmt_byte;

  // Sequencer and output register
  gdps_seq #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .CHARS_PER_ROW(CHARS_PER_ROW),
    .TEXT_ROWS    (TEXT_ROWS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .pos        (pos),
    .fmt_is_data(fmt_is_data),
    .fmt_byte   (fmt_byte)
  );

  // Glyph memory
  gdps_ram #(
    .WIDTH(gdps_pkg::BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Command and pixel byte formatter
  gdps_fmt u_fmt (
    .pos     (pos),
    .rdata   (ram_rdata),
    .is_data (fmt_is_data),
    .byte_val(fmt_byte)
  );

endmodule

// File: src/gdps_ram.sv
// ----------------------------------------------------------------------------
// gdps_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/gdps_fmt.sv
// ----------------------------------------------------------------------------
// gdps_fmt: byte formatter
// Builds the command or pixel byte for the current page and step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdps_fmt (
  input  gdps_pkg::pos_t              pos,
  input  logic [gdps_pkg::BYTE_W-1:0] rdata,
  output logic                        is_data,
  output logic [gdps_pkg::BYTE_W-1:0] byte_val
);

  logic [3:0]                  nib;
  logic [gdps_pkg::BYTE_W-1:0] pix;

  // Pick the nibble for this page, blank for codes outside the font
  assign nib = pos.page[0] ? rdata[7:4] : rdata[3:0];
  assign pix = pos.glyph_ok ? gdps_pkg::spread_nibble(nib) : '0;

  // Select positioning command or pixel byte
  always_comb begin
    is_data = 1'b0;
    unique case (pos.step)
      gdps_pkg::STEP_CMD_PAGE: byte_val = gdps_pkg::CMD_PAGE | {5'b0, pos.trow, pos.page};
      gdps_pkg::STEP_CMD_HI:   byte_val = gdps_pkg::CMD_COL_HI | {5'b0, pos.col[3:1]};
      gdps_pkg::STEP_CMD_LO:   byte_val = gdps_pkg::CMD_COL_LO | {4'b0, pos.col[0], 3'b0};
      default: begin
        is_data  = 1'b1;
        byte_val = pix;
      end
    endcase
  end

endmodule

// File: src/gdps_seq.sv
// ----------------------------------------------------------------------------
// gdps_seq: draw sequencer
// Walks four pages of eleven steps, drives glyph reads and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdps_seq #(
  parameter int unsigned GLYPH_COUNT   = 96,
  parameter int unsigned CHARS_PER_ROW = 16,
  parameter int unsigned TEXT_ROWS     = 2
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  gdps_in_if.sink                                 in_ch,
  gdps_out_if.source                              out_ch,
  output logic                                    ram_we,
  output logic [$clog2(GLYPH_COUNT*16)-1:0]       ram_waddr,
  output logic [gdps_pkg::BYTE_W-1:0]             ram_wdata,
  output logic [$clog2(GLYPH_COUNT*16)-1:0]       ram_raddr,
  output gdps_pkg::pos_t                          pos,
  input  logic                                    fmt_is_data,
  input  logic [gdps_pkg::BYTE_W-1:0]             fmt_byte
);

  localparam int unsigned AW = $clog2(GLYPH_COUNT * 16);

  typedef enum logic {S_IDLE, S_DRAW} state_t;

  state_t                          state_r, state_nxt;
  logic [gdps_pkg::PAGE_W-1:0]     page_r, page_nxt;
  logic [gdps_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [gdps_pkg::COL_W-1:0]      col_r, col_nxt;
  logic                            trow_r, trow_nxt;
  logic [gdps_pkg::GIDX_W-1:0]     gidx_r, gidx_nxt;
  logic                            gok_r, gok_nxt;
  logic                            ov_r, ov_nxt;
  logic                            od_r, od_nxt;
  logic [gdps_pkg::BYTE_W-1:0]     ob_r, ob_nxt;
  logic                            ol_r, ol_nxt;

  logic                            in_xfer;
  logic                            load;
  logic                            at_end;
  logic [gdps_pkg::GIDX_W-1:0]     in_gidx;
  logic                            in_gok;
  logic [gdps_pkg::STEP_W-1:0]     row_off;
  logic [gdps_pkg::ADDR_EXT_W-1:0] raddr_ext;
  logic [gdps_pkg::ADDR_EXT_W-1:0] waddr_ext;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign load        = (state_r == S_DRAW) && (!ov_r || out_ch.ready);
  assign at_end      = (page_r == gdps_pkg::PAGE_LAST) && (step_r == gdps_pkg::STEP_LAST);

  // Glyph index and range check of the drawn character
  assign in_gidx = in_ch.char_code - gdps_pkg::CODE_BASE;
  assign in_gok  = (in_ch.char_code >= gdps_pkg::CODE_BASE)
                && ({1'b0, in_gidx} < 9'(GLYPH_COUNT));

  // Glyph memory write on a load transfer within range
  assign waddr_ext = {1'b0, in_ch.font_addr};
  assign ram_we    = in_xfer && (in_ch.op == gdps_pkg::OP_LOAD)
                  && (waddr_ext < gdps_pkg::ADDR_EXT_W'(GLYPH_COUNT * 16));
  assign ram_waddr = waddr_ext[AW-1:0];
  assign ram_wdata = in_ch.font_byte;

  // Read ahead from the next position so data matches the step it is used in
  assign row_off   = step_nxt - gdps_pkg::STEP_DATA0;
  assign raddr_ext = {gidx_nxt, page_nxt[1], row_off[2:0]};
  assign ram_raddr = raddr_ext[AW-1:0];

  assign pos = '{page: page_r, step: step_r, col: col_r, trow: trow_r, glyph_ok: gok_r};

  assign out_ch.valid    = ov_r;
  assign out_ch.is_data  = od_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.last     = ol_r;

  // Next state: start a draw, then load one byte per free output slot
  always_comb begin
    state_nxt = state_r;
    page_nxt  = page_r;
    step_nxt  = step_r;
    col_nxt   = col_r;
    trow_nxt  = trow_r;
    gidx_nxt  = gidx_r;
    gok_nxt   = gok_r;
    ov_nxt    = ov_r && !out_ch.ready;
    od_nxt    = od_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_ch.op == gdps_pkg::OP_DRAW)) begin
          state_nxt = S_DRAW;
          page_nxt  = '0;
          step_nxt  = gdps_pkg::STEP_CMD_PAGE;
          gidx_nxt  = in_gidx;
          gok_nxt   = in_gok;
        end
      end
      S_DRAW: begin
        if (load) begin
          ov_nxt = 1'b1;
          od_nxt = fmt_is_data;
          ob_nxt = fmt_byte;
          ol_nxt = at_end;
          if (at_end) begin
            state_nxt = S_IDLE;
            // Advance the text slot, wrap after the last row
            if (col_r == gdps_pkg::COL_W'(CHARS_PER_ROW - 1)) begin
              col_nxt  = '0;
              trow_nxt = (trow_r == 1'(TEXT_ROWS - 1)) ? 1'b0 : !trow_r;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end else if (step_r == gdps_pkg::STEP_LAST) begin
            step_nxt = gdps_pkg::STEP_CMD_PAGE;
            page_nxt = page_r + 1'b1;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, slot and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      trow_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      trow_r  <= trow_nxt;
      ov_r    <= ov_nxt;
    end
    page_r <= page_nxt;
    step_r <= step_nxt;
    gidx_r <= gidx_nxt;
    gok_r  <= gok_nxt;
    od_r   <= od_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

endmodule

// File: src/gdps_chk.sv
// ----------------------------------------------------------------------------
// gdps_chk: port checker for the glyph page stream renderer
// Watches the item and byte channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdps_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_is_data,
  input logic [gdps_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last
);

  // Hold a stalled byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("stalled output byte changed");

  // Stop taking items once a draw starts
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == gdps_pkg::OP_DRAW)) |=> !in_ready)
    else $error("item taken right after a draw transfer");

  // Take no item while a draw still has bytes to go
  a_mid_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !in_ready)
    else $error("item channel ready in the middle of a draw");

  // Follow every non-final byte transfer with the next byte at once
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside a draw");

  // Pixel bytes use odd bits only
  a_pix_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_data) |-> ((out_byte & 8'h55) == 8'h00))
    else $error("pixel byte has an even bit set");

endmodule

bind glyph_to_display_page_stream_core gdps_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_op      (in_ch.op),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_is_data(out_ch.is_data),
  .out_byte   (out_ch.out_byte),
  .out_last   (out_ch.last)
);
